// ===== hdl/srrd_pkg.sv =====
// ---------------------------------------------------------------------------
// srrd_pkg
// Shared types, widths and codes for the sprite row decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package srrd_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned PIX_W       = 16;
  localparam int unsigned LIT_W       = 15;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned MAX_DIM_DEF = 4096;
  localparam int unsigned ROW_CAP     = 4096;

  localparam logic [PIX_W-1:0] TRANSPARENT  = 16'h00FF;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd64;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd64;

  localparam logic KIND_SPAN  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_WIDE_PIXELS  = 2'd2,
    REG_UNUSED       = 2'd3
  } srrd_reg_t;

  typedef enum logic [2:0] {
    PH_END_LO = 3'd0,
    PH_END_HI = 3'd1,
    PH_CNT_LO = 3'd2,
    PH_CNT_HI = 3'd3,
    PH_LIT    = 3'd4,
    PH_LIT_HI = 3'd5
  } srrd_phase_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             wide_pixels;
  } srrd_cfg_t;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] pos_x;
    logic [ROW_W-1:0] pos_y;
    logic [CNT_W-1:0] span_count;
    logic [PIX_W-1:0] pixel_value;
    logic             row_end;
    logic             last_result;
  } srrd_result_t;

  typedef struct packed {
    logic [1:0]   count;
    srrd_result_t res_a;
    srrd_result_t res_b;
  } srrd_batch_t;

endpackage

`default_nettype wire

// ===== hdl/srrd_if.sv =====
// ---------------------------------------------------------------------------
// srrd_if
// Valid/ready channels: the coded byte stream and the decoded results.
// ---------------------------------------------------------------------------
`default_nettype none

interface srrd_byte_if;
  import srrd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface srrd_res_if;
  import srrd_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [POS_W-1:0] pos_x;
  logic [ROW_W-1:0] pos_y;
  logic [CNT_W-1:0] span_count;
  logic [PIX_W-1:0] pixel_value;
  logic             row_end;
  logic             last_result;

  modport source (output valid, output kind, output pos_x, output pos_y, output span_count,
                  output pixel_value, output row_end, output last_result, input ready);
  modport sink (input valid, input kind, input pos_x, input pos_y, input span_count,
                input pixel_value, input row_end, input last_result, output ready);
endinterface

`default_nettype wire

// ===== hdl/srrd_regs.sv =====
// ---------------------------------------------------------------------------
// srrd_regs
// APB register bank: image width, image height and pixel mode.
// ---------------------------------------------------------------------------
`default_nettype none

module srrd_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [srrd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [srrd_pkg::APB_DW-1:0] pwdata,
  output logic      [srrd_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output srrd_pkg::srrd_cfg_t             cfg
);
  import srrd_pkg::*;

  srrd_reg_t reg_sel;
  logic      wr_en;

  assign reg_sel = srrd_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= WIDTH_RESET;
      cfg.image_height <= HEIGHT_RESET;
      cfg.wide_pixels  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[DIM_W-1:0];
        REG_WIDE_PIXELS:  cfg.wide_pixels  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, cfg.image_width};
      REG_IMAGE_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, cfg.image_height};
      REG_WIDE_PIXELS:  prdata = {{(APB_DW-1){1'b0}}, cfg.wide_pixels};
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/srrd_core.sv =====
// ---------------------------------------------------------------------------
// srrd_core
// Segment parser: header phases, span and pixel results, row bookkeeping.
// ---------------------------------------------------------------------------
`default_nettype none

module srrd_core #(
  parameter int unsigned MAX_DIM = srrd_pkg::MAX_DIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire srrd_pkg::srrd_cfg_t        cfg,
  input  wire logic                       take,
  input  wire logic [srrd_pkg::DATA_W-1:0] data_byte,
  output srrd_pkg::srrd_batch_t           batch
);
  import srrd_pkg::*;

  localparam int unsigned ROW_LIM = (MAX_DIM < ROW_CAP) ? MAX_DIM : ROW_CAP;
  localparam logic [DIM_W-1:0] H_LIM = DIM_W'(ROW_LIM);
  localparam logic [POS_W:0]   W_LIM = (POS_W+1)'(MAX_DIM);

  srrd_phase_t       phase, phase_next;
  logic [DATA_W-1:0] low_byte_latch, latch_next;
  logic [POS_W-1:0]  segment_end, end_next;
  logic [POS_W-1:0]  column, column_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [LIT_W-1:0]  literals_left, lit_next;
  logic              last_segment, last_next;

  logic              narrow;
  logic [POS_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_nz, h_eff, row_inc;
  logic [ROW_W-1:0]  row_wrap;
  logic [LIT_W-1:0]  lit_new, lit_dec;
  logic [POS_W:0]    need_sum;
  logic              gap_pos;
  logic [POS_W-1:0]  gap, end_minus_lit, column_inc;

  logic              a_valid, a_kind, b_valid;
  logic [CNT_W-1:0]  a_count;
  logic [PIX_W-1:0]  a_value;
  logic [POS_W-1:0]  col_a;
  logic              seg_done, seg_last, fill_en, finish, both;
  srrd_result_t      ra, rb;

  // clamped dimensions
  assign narrow = !cfg.wide_pixels;
  assign w_eff  = ({{(POS_W+1-DIM_W){1'b0}}, cfg.image_width} > W_LIM) ?
                  W_LIM[POS_W-1:0] : {{(POS_W-DIM_W){1'b0}}, cfg.image_width};
  assign h_nz     = (cfg.image_height == '0) ? DIM_W'(1) : cfg.image_height;
  assign h_eff    = (h_nz > H_LIM) ? H_LIM : h_nz;
  assign row_inc  = {1'b0, row} + DIM_W'(1);
  assign row_wrap = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];

  // segment header arithmetic
  assign lit_new       = {data_byte[6:0], low_byte_latch};
  assign lit_dec       = literals_left - LIT_W'(1);
  assign need_sum      = {1'b0, column} + {{(POS_W+1-LIT_W){1'b0}}, lit_new};
  assign gap_pos       = {1'b0, segment_end} > need_sum;
  assign gap           = segment_end - need_sum[POS_W-1:0];
  assign end_minus_lit = segment_end - {{(POS_W-LIT_W){1'b0}}, lit_new};
  assign column_inc    = column + POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_END_LO;
      low_byte_latch <= '0;
      segment_end    <= '0;
      column         <= '0;
      row            <= '0;
      literals_left  <= '0;
      last_segment   <= 1'b0;
    end else begin
      phase          <= phase_next;
      low_byte_latch <= latch_next;
      segment_end    <= end_next;
      column         <= column_next;
      row            <= row_next;
      literals_left  <= lit_next;
      last_segment   <= last_next;
    end
  end

  always_comb begin
    phase_next = phase;
    latch_next = low_byte_latch;
    end_next   = segment_end;
    lit_next   = literals_left;
    last_next  = last_segment;
    col_a      = column;
    a_valid    = 1'b0;
    a_kind     = KIND_SPAN;
    a_count    = CNT_W'(1);
    a_value    = TRANSPARENT;
    seg_done   = 1'b0;
    seg_last   = last_segment;
    fill_en    = 1'b0;

    if (take) begin
      unique case (phase)
        PH_END_LO: begin
          latch_next = data_byte;
          phase_next = PH_END_HI;
        end
        PH_END_HI: begin
          end_next   = {data_byte, low_byte_latch};
          phase_next = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          latch_next = data_byte;
          phase_next = PH_CNT_HI;
        end
        PH_CNT_HI: begin
          lit_next  = lit_new;
          last_next = data_byte[7];
          seg_last  = data_byte[7];
          fill_en   = narrow;
          if (narrow) begin
            // transparent gap ahead of the literals, none if it is not positive
            if (gap_pos) begin
              a_valid = 1'b1;
              a_count = gap;
              col_a   = end_minus_lit;
            end
          end else begin
            col_a = end_minus_lit;
          end
          if (lit_new == '0) begin
            seg_done = 1'b1;
          end else begin
            phase_next = PH_LIT;
          end
        end
        PH_LIT: begin
          if (narrow) begin
            a_valid  = 1'b1;
            a_kind   = KIND_PIXEL;
            a_value  = {{(PIX_W-DATA_W){1'b0}}, data_byte};
            col_a    = column_inc;
            lit_next = lit_dec;
            fill_en  = 1'b1;
            seg_done = (lit_dec == '0);
          end else begin
            latch_next = data_byte;
            phase_next = PH_LIT_HI;
          end
        end
        PH_LIT_HI: begin
          a_valid  = 1'b1;
          a_kind   = KIND_PIXEL;
          a_value  = {data_byte, low_byte_latch};
          col_a    = column_inc;
          lit_next = lit_dec;
          if (lit_dec == '0) begin
            seg_done = 1'b1;
          end else begin
            phase_next = PH_LIT;
          end
        end
        default: phase_next = PH_END_LO;
      endcase
    end

    if (seg_done) begin
      phase_next = PH_END_LO;
    end
    finish      = seg_done && seg_last;
    column_next = finish ? '0 : col_a;
    row_next    = finish ? row_wrap : row;
    b_valid     = finish && fill_en && (col_a < w_eff);
    both        = a_valid && b_valid;

    // result a is the gap span or the pixel, result b the trailing row fill
    ra.kind        = a_kind;
    ra.pos_x       = column;
    ra.pos_y       = row;
    ra.span_count  = a_count;
    ra.pixel_value = a_value;
    ra.row_end     = finish;
    ra.last_result = 1'b1;

    rb.kind        = KIND_SPAN;
    rb.pos_x       = col_a;
    rb.pos_y       = row;
    rb.span_count  = w_eff - col_a;
    rb.pixel_value = TRANSPARENT;
    rb.row_end     = 1'b1;
    rb.last_result = 1'b1;

    batch.count = {both, a_valid ^ b_valid};
    batch.res_a = a_valid ? ra : rb;
    batch.res_b = rb;
    if (both) begin
      batch.res_a.row_end     = 1'b0;
      batch.res_a.last_result = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/srrd_outq.sv =====
// ---------------------------------------------------------------------------
// srrd_outq
// Two-entry result register between the parser and the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module srrd_outq (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   take,
  input  wire srrd_pkg::srrd_batch_t  batch,
  output logic                        load_ok,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output srrd_pkg::srrd_result_t      head
);
  import srrd_pkg::*;

  logic [1:0]   cnt;
  srrd_result_t tail;
  logic         fire;

  assign out_valid = (cnt != 2'd0);
  assign fire      = out_valid && out_ready;
  // a new batch may land only once whatever is held leaves this cycle
  assign load_ok   = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (take) begin
      cnt <= batch.count;
    end else if (fire) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      head <= batch.res_a;
      tail <= batch.res_b;
    end else if (fire) begin
      head <= tail;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sprite_row_rle_decoder.sv =====
// ---------------------------------------------------------------------------
// sprite_row_rle_decoder
// Row-coded sprite decoder: bytes in, transparent spans and pixels out.
// ---------------------------------------------------------------------------
// usage
//   stream  : one coded byte per request; each segment is a 16-bit end
//             position and a 16-bit literal count (bit 15 = last segment),
//             both little endian, then the literal bytes or 16-bit words
//   result  : one span or pixel per request, with row and column, a row_end
//             flag and a last_result flag on the final result of a byte
//   apb     : image_width at 0x0, image_height at 0x4, wide_pixels at 0x8;
//             write only while the block is idle
// latency and throughput
//   a result is presented the cycle after its byte is taken; one byte a
//   cycle while results drain; a byte that makes two results (gap span plus
//   row fill, or pixel plus row fill) holds the stream until the first of
//   them has left the single result channel
// reset
//   rst (synchronous) clears the parser to the start of a segment on row 0
//   and sets width 64, height 64 and 8-bit pixels
// stalls
//   up to two results are held; with two held, or one held and result.ready
//   low, the stream is held off, nothing is dropped
// ---------------------------------------------------------------------------
`default_nettype none

module sprite_row_rle_decoder #(
  parameter int unsigned MAX_DIM = srrd_pkg::MAX_DIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  srrd_byte_if.sink                       stream,
  srrd_res_if.source                      result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [srrd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [srrd_pkg::APB_DW-1:0] pwdata,
  output logic      [srrd_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import srrd_pkg::*;

  srrd_cfg_t    cfg;
  srrd_batch_t  batch;
  srrd_result_t head;
  logic         load_ok;
  logic         take;

  // register bank
  srrd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // byte accepted when the result register can take its results
  assign stream.ready = load_ok;
  assign take         = stream.valid && load_ok;

  // parser: phase state plus up to two results for the byte taken
  srrd_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .data_byte (stream.data_byte),
    .batch     (batch)
  );

  // result register, drained one result per request
  srrd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .batch     (batch),
    .load_ok   (load_ok),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .head      (head)
  );

  assign result.kind        = head.kind;
  assign result.pos_x       = head.pos_x;
  assign result.pos_y       = head.pos_y;
  assign result.span_count  = head.span_count;
  assign result.pixel_value = head.pixel_value;
  assign result.row_end     = head.row_end;
  assign result.last_result = head.last_result;

endmodule

`default_nettype wire
